[src/ptts_pkg.sv]
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants of the periodic task table scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

    // Default table depth and key width.
    localparam int SLOTS_DEF    = 16;
    localparam int KEY_BITS_DEF = 8;

    // Period from frequency: dividend and clamp value.
    localparam int DIVIDEND = 1000;
    localparam int FREQ_MAX = 50;
    localparam int QUO_W    = 10;
    localparam int DIV_W    = 6;

    // Options byte bits.
    localparam int OPT_PAUSE   = 0;
    localparam int OPT_DISPOSE = 1;

    // Request codes.
    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_ADD     = 3'd1,
        REQ_FREQ    = 3'd2,
        REQ_ONESHOT = 3'd3,
        REQ_REMOVE  = 3'd4,
        REQ_PAUSE   = 3'd5,
        REQ_RESUME  = 3'd6,
        REQ_NONE    = 3'd7
    } t_req_code;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_FIRED     = 3'd0,
        ST_DONE      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_IDLE      = 3'd4,
        ST_BAD_FREQ  = 3'd5
    } t_status;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIND,
        S_TICK
    } t_state;

    // Request transaction.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  task_key;
        logic [31:0] now_ms;
        logic [31:0] period_or_freq;
        logic [7:0]  option_bits;
    } t_req;

    // Result transaction.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] out_key;
        logic [4:0] live_count;
        logic       last;
    } t_res;

endpackage

`default_nettype wire

[src/periodic_task_table_scheduler.sv]
// ----------------------------------------------------------------------------
// periodic_task_table_scheduler
// Ordered table of periodic tasks with tick, add, one-shot, remove, pause and
// resume requests, walked one slot per cycle by a small sequencer.
// ----------------------------------------------------------------------------
// Channel   | Direction | Handshake             | Payload
// request   | in        | start high, busy low  | i_req  (ptts_pkg::t_req)
// result    | out       | o_res_stb, one cycle  | o_res  (ptts_pkg::t_res)
//
// A tick or a key lookup visits one slot per cycle.
// Add by frequency first runs the divider, then the lookup.
// A tick shows one result per fired task, the last as the walk ends, or one
// idle result if none fired; each is shown for one cycle and cannot be stalled.
// Reset empties the table; slot contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_table_scheduler #(
    parameter int SLOTS    = ptts_pkg::SLOTS_DEF,
    parameter int KEY_BITS = ptts_pkg::KEY_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire ptts_pkg::t_req i_req,
    output logic                o_res_stb,
    output ptts_pkg::t_res      o_res
);

    localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CntW = $clog2(SLOTS + 1);
    localparam logic [7:0] KeyMask = (KEY_BITS >= 8) ? 8'hFF : 8'((1 << KEY_BITS) - 1);

    // Task table.
    logic [7:0]  r_skey [SLOTS];
    logic [31:0] r_sper [SLOTS];
    logic [31:0] r_sstp [SLOTS];
    logic [7:0]  r_sopt [SLOTS];

    ptts_pkg::t_state r_state, n_state;
    ptts_pkg::t_req   r_req;
    logic [CntW-1:0]  r_idx, n_idx;
    logic [CntW-1:0]  r_count, n_count;
    logic             r_stb, n_stb;
    ptts_pkg::t_res   r_res, n_res;
    logic             r_have, n_have;
    logic [7:0]       r_hkey, n_hkey;
    logic [CntW-1:0]  r_hcnt, n_hcnt;
    logic [31:0]      r_fper;

    logic                         accept;
    logic                         div_start;
    logic                         div_done;
    logic [ptts_pkg::QUO_W-1:0]   div_quo;
    logic [ptts_pkg::DIV_W-1:0]   freq_clamped;

    logic [IdxW-1:0] j;
    logic            in_range;
    logic [7:0]      e_key;
    logic [31:0]     e_per;
    logic [31:0]     e_stp;
    logic [7:0]      e_opt;
    logic            due;
    logic [31:0]     eff_per;

    logic            w_shift;
    logic [IdxW-1:0] w_idx;
    logic            w_key_en, w_per_en, w_stp_en, w_opt_en;
    logic [7:0]      w_key_v;
    logic [31:0]     w_per_v;
    logic [31:0]     w_stp_v;
    logic [7:0]      w_opt_v;

    assign accept = start && !busy;
    assign busy   = (r_state != ptts_pkg::S_IDLE);

    // Clamp the frequency for the divider.
    assign freq_clamped = (i_req.period_or_freq > 32'(ptts_pkg::FREQ_MAX))
                        ? ptts_pkg::DIV_W'(ptts_pkg::FREQ_MAX)
                        : ptts_pkg::DIV_W'(i_req.period_or_freq);

    ptts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (freq_clamped),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Slot under the walk pointer.
    assign j        = IdxW'(r_idx);
    assign in_range = r_idx < r_count;
    assign e_key    = r_skey[j];
    assign e_per    = r_sper[j];
    assign e_stp    = r_sstp[j];
    assign e_opt    = r_sopt[j];
    assign due      = !e_opt[ptts_pkg::OPT_PAUSE] && ((r_req.now_ms - e_stp) >= e_per);
    assign eff_per  = (r_req.req_type == ptts_pkg::REQ_FREQ) ? r_fper : r_req.period_or_freq;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptts_pkg::S_IDLE;
            r_idx   <= '0;
            r_count <= '0;
            r_stb   <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_stb   <= n_stb;
            r_have  <= n_have;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_hkey <= n_hkey;
        r_hcnt <= n_hcnt;
        if (accept) begin
            r_req <= '{req_type: i_req.req_type,
                       task_key: i_req.task_key & KeyMask,
                       now_ms: i_req.now_ms,
                       period_or_freq: i_req.period_or_freq,
                       option_bits: i_req.option_bits};
        end
        if (div_done) begin
            r_fper <= 32'(div_quo);
        end
    end

    // Sequencer: next state, results and table writes.
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_count   = r_count;
        n_stb     = 1'b0;
        n_res     = r_res;
        n_have    = r_have;
        n_hkey    = r_hkey;
        n_hcnt    = r_hcnt;
        div_start = 1'b0;
        w_shift   = 1'b0;
        w_idx     = j;
        w_key_en  = 1'b0;
        w_per_en  = 1'b0;
        w_stp_en  = 1'b0;
        w_opt_en  = 1'b0;
        w_key_v   = r_req.task_key;
        w_per_v   = eff_per;
        w_stp_v   = r_req.now_ms;
        w_opt_v   = r_req.option_bits;

        unique case (r_state)
            ptts_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx  = '0;
                    n_have = 1'b0;
                    case (i_req.req_type) inside
                        ptts_pkg::REQ_TICK: begin
                            n_state = ptts_pkg::S_TICK;
                        end
                        ptts_pkg::REQ_FREQ: begin
                            if (i_req.period_or_freq == '0) begin
                                n_stb = 1'b1;
                                n_res = '{status: ptts_pkg::ST_BAD_FREQ,
                                          out_key: i_req.task_key & KeyMask,
                                          live_count: 5'(r_count), last: 1'b1};
                            end else begin
                                div_start = 1'b1;
                                n_state   = ptts_pkg::S_DIV;
                            end
                        end
                        ptts_pkg::REQ_ADD, ptts_pkg::REQ_ONESHOT, ptts_pkg::REQ_REMOVE,
                        ptts_pkg::REQ_PAUSE, ptts_pkg::REQ_RESUME: begin
                            n_state = ptts_pkg::S_FIND;
                        end
                        default: begin
                            n_state = ptts_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            ptts_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = ptts_pkg::S_FIND;
                end
            end

            ptts_pkg::S_FIND: begin
                if (in_range && e_key == r_req.task_key) begin
                    // Key found: update the slot in place.
                    n_state = ptts_pkg::S_IDLE;
                    n_stb   = 1'b1;
                    n_res   = '{status: ptts_pkg::ST_DONE, out_key: r_req.task_key,
                                live_count: 5'(r_count), last: 1'b1};
                    w_opt_en = 1'b1;
                    case (r_req.req_type) inside
                        ptts_pkg::REQ_ADD, ptts_pkg::REQ_FREQ: begin
                            w_per_en = 1'b1;
                        end
                        ptts_pkg::REQ_ONESHOT: begin
                            w_per_en = 1'b1;
                            w_stp_en = 1'b1;
                            w_opt_v[ptts_pkg::OPT_DISPOSE] = 1'b1;
                        end
                        ptts_pkg::REQ_REMOVE: begin
                            w_opt_v = e_opt;
                            w_opt_v[ptts_pkg::OPT_DISPOSE] = 1'b1;
                        end
                        ptts_pkg::REQ_PAUSE: begin
                            w_opt_v = e_opt;
                            w_opt_v[ptts_pkg::OPT_PAUSE] = 1'b1;
                        end
                        default: begin
                            w_opt_v = e_opt;
                            w_opt_v[ptts_pkg::OPT_PAUSE] = 1'b0;
                        end
                    endcase
                end else if (in_range) begin
                    n_idx = r_idx + CntW'(1);
                end else begin
                    // Walked off the end: append, or report absence or a full table.
                    n_state = ptts_pkg::S_IDLE;
                    n_stb   = 1'b1;
                    if (r_req.req_type == ptts_pkg::REQ_REMOVE ||
                        r_req.req_type == ptts_pkg::REQ_PAUSE ||
                        r_req.req_type == ptts_pkg::REQ_RESUME) begin
                        n_res = '{status: ptts_pkg::ST_NOT_FOUND, out_key: r_req.task_key,
                                  live_count: 5'(r_count), last: 1'b1};
                    end else if (r_count == CntW'(SLOTS)) begin
                        n_res = '{status: ptts_pkg::ST_FULL, out_key: r_req.task_key,
                                  live_count: 5'(r_count), last: 1'b1};
                    end else begin
                        n_count  = r_count + CntW'(1);
                        w_idx    = IdxW'(r_count);
                        w_key_en = 1'b1;
                        w_per_en = 1'b1;
                        w_stp_en = 1'b1;
                        w_opt_en = 1'b1;
                        if (r_req.req_type == ptts_pkg::REQ_ONESHOT) begin
                            w_opt_v[ptts_pkg::OPT_DISPOSE] = 1'b1;
                        end else begin
                            w_stp_v = '0;
                        end
                        n_res = '{status: ptts_pkg::ST_DONE, out_key: r_req.task_key,
                                  live_count: 5'(n_count), last: 1'b1};
                    end
                end
            end

            ptts_pkg::S_TICK: begin
                if (in_range) begin
                    if (due) begin
                        // Release the previous fire; hold this one until the next fire or the walk's end.
                        if (r_have) begin
                            n_stb = 1'b1;
                            n_res = '{status: ptts_pkg::ST_FIRED, out_key: r_hkey,
                                      live_count: 5'(r_hcnt), last: 1'b0};
                        end
                        n_have = 1'b1;
                        n_hkey = e_key;
                        if (e_opt[ptts_pkg::OPT_DISPOSE]) begin
                            w_shift = 1'b1;
                            n_count = r_count - CntW'(1);
                        end else begin
                            w_stp_en = 1'b1;
                            n_idx    = r_idx + CntW'(1);
                        end
                        n_hcnt = n_count;
                    end else begin
                        n_idx = r_idx + CntW'(1);
                    end
                end else begin
                    n_state = ptts_pkg::S_IDLE;
                    n_stb   = 1'b1;
                    if (r_have) begin
                        n_res = '{status: ptts_pkg::ST_FIRED, out_key: r_hkey,
                                  live_count: 5'(r_hcnt), last: 1'b1};
                    end else begin
                        n_res = '{status: ptts_pkg::ST_IDLE, out_key: 8'd0,
                                  live_count: 5'(r_count), last: 1'b1};
                    end
                end
            end

            default: begin
                n_state = ptts_pkg::S_IDLE;
            end
        endcase
    end

    // Table storage: in-place writes and order-keeping compaction.
    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        if (g < SLOTS - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (w_shift && g >= int'(w_idx)) begin
                    r_skey[g] <= r_skey[g+1];
                    r_sper[g] <= r_sper[g+1];
                    r_sstp[g] <= r_sstp[g+1];
                    r_sopt[g] <= r_sopt[g+1];
                end else if (g == int'(w_idx)) begin
                    if (w_key_en) r_skey[g] <= w_key_v;
                    if (w_per_en) r_sper[g] <= w_per_v;
                    if (w_stp_en) r_sstp[g] <= w_stp_v;
                    if (w_opt_en) r_sopt[g] <= w_opt_v;
                end
            end
        end else begin : g_end
            always_ff @(posedge i_clk) begin
                if (!w_shift && g == int'(w_idx)) begin
                    if (w_key_en) r_skey[g] <= w_key_v;
                    if (w_per_en) r_sper[g] <= w_per_v;
                    if (w_stp_en) r_sstp[g] <= w_stp_v;
                    if (w_opt_en) r_sopt[g] <= w_opt_v;
                end
            end
        end
    end

    assign o_res_stb = r_stb;
    assign o_res     = r_res;

`ifndef SYNTHESIS
    // The task count never exceeds the table depth.
    a_count_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(SLOTS))
        else $error("task count above table depth");
    // A result that is not the last of its request appears while still busy.
    a_not_last_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_stb && !o_res.last |-> busy)
        else $error("non-final result shown while idle");
    // The divider finishes only while the sequencer waits for it.
    a_div_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ptts_pkg::S_DIV)
        else $error("divider result outside the divide state");
`endif

endmodule

`default_nettype wire

[src/ptts_div.sv]
// ----------------------------------------------------------------------------
// ptts_div
// Restoring divider that computes 1000 / divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [ptts_pkg::DIV_W-1:0]   i_divisor,
    output logic                              o_done,
    output logic [ptts_pkg::QUO_W-1:0]        o_quotient
);

    localparam logic [ptts_pkg::QUO_W-1:0] Dividend = ptts_pkg::QUO_W'(ptts_pkg::DIVIDEND);
    localparam int CntW = $clog2(ptts_pkg::QUO_W);

    logic                        r_busy;
    logic [CntW-1:0]             r_cnt;
    logic [ptts_pkg::DIV_W-1:0]  r_rem;
    logic [ptts_pkg::DIV_W-1:0]  r_dvs;
    logic [ptts_pkg::QUO_W-1:0]  r_quo;
    logic                        r_done;
    logic [ptts_pkg::DIV_W:0]    trial;
    logic                        fits;

    // One restoring step: bring down the next dividend bit and try to subtract.
    assign trial = {r_rem, Dividend[r_cnt]};
    assign fits  = trial >= {1'b0, r_dvs};

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(ptts_pkg::QUO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? ptts_pkg::DIV_W'(trial - {1'b0, r_dvs})
                          : ptts_pkg::DIV_W'(trial);
            r_quo <= {r_quo[ptts_pkg::QUO_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef SYNTHESIS
    // The divisor is at most 50, so the quotient is never below 20.
    a_quo_min : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_quo >= ptts_pkg::QUO_W'(ptts_pkg::DIVIDEND / ptts_pkg::FREQ_MAX))
        else $error("divider quotient too small");
    // A result comes only in the cycle after a running division.
    a_done_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
    // The remainder always stays below the divisor.
    a_rem_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !$past(i_start) |-> r_rem < r_dvs)
        else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
